[sv/clip_fade_gain_and_loop_address_top_macros.svh]
// assertion macros shared by the checker
`ifndef CLIP_FADE_GAIN_AND_LOOP_ADDRESS_TOP_MACROS_SVH
`define CLIP_FADE_GAIN_AND_LOOP_ADDRESS_TOP_MACROS_SVH

// same-cycle implication, off during reset
`define CFGLA_ASSERT_NOW(label, cond, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, off during reset
`define CFGLA_ASSERT_NEXT(label, cond, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
    else $error("assertion failed");

// next-cycle implication, checked during reset too
`define CFGLA_ASSERT_NEXT_RST(label, cond, cons) \
  label: assert property (@(posedge clk) (cond) |=> (cons)) \
    else $error("assertion failed");

`endif

[sv/cfgla_pkg.sv]
// ----------------------------------------------------------------------------
// cfgla_pkg
// widths, register indexes and stage record of the clip fade gain block
// ----------------------------------------------------------------------------
package cfgla_pkg;

  localparam int FRAME_BITS = 32;
  localparam int GAIN_BITS  = 16;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = (FRAME_BITS > GAIN_BITS) ? FRAME_BITS : GAIN_BITS;
  // signed width for duration and fade-out window math
  localparam int SGN_BITS = FRAME_BITS + 3;
  localparam int FADE_END = 2 * GAIN_BITS + 2;
  localparam int LAST_STAGE = ((FRAME_BITS > FADE_END) ? FRAME_BITS : FADE_END) + 1;

  localparam logic [GAIN_BITS-1:0] GAIN_RESET = GAIN_BITS'(4096);

  localparam logic [CFG_IDX_BITS-1:0] REG_LINEAR_GAIN = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_FADE_IN     = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_FADE_OUT    = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_START       = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_END         = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_MUTED       = 3'd5;
  localparam logic [CFG_IDX_BITS-1:0] REG_LOOPED      = 3'd6;

  typedef struct packed {
    logic [FRAME_BITS-1:0] off;
    logic [FRAME_BITS-1:0] mr;
    logic [FRAME_BITS-1:0] rr;
    logic [GAIN_BITS-1:0]  lq;
    logic [GAIN_BITS-1:0]  g;
    logic [FRAME_BITS-1:0] rem;
    logic                  fi_hit;
    logic                  fo_hit;
    logic                  fo_zero;
    logic [FRAME_BITS:0]   src;
    logic                  in_range;
  } cfgla_stage_t;

  // one restoring division step: {new remainder, quotient bit}
  function automatic logic [FRAME_BITS:0] div_step(input logic [FRAME_BITS-1:0] r,
                                                   input logic b,
                                                   input logic [FRAME_BITS-1:0] d);
    logic [FRAME_BITS:0] t;
    logic [FRAME_BITS:0] s;
    t = {r, b};
    s = t - {1'b0, d};
    if (t >= {1'b0, d}) begin
      div_step = {s[FRAME_BITS-1:0], 1'b1};
    end else begin
      div_step = {t[FRAME_BITS-1:0], 1'b0};
    end
  endfunction

endpackage

[sv/clip_fade_gain_and_loop_address_top.sv]
// ----------------------------------------------------------------------------
// clip_fade_gain_and_loop_address_top
// source frame, range flag and faded gain for each clip frame offset
// ----------------------------------------------------------------------------
// Usage:
//   frame channel: frame_offset with frame_valid; a transaction is taken at
//   a clock edge with frame_valid high and frame_stall low.
//   result channel: source_frame, in_range and gain with result_valid; the
//   receiver holds result_stall high to keep the result in place.
//   config channel: cfg_index / cfg_data with cfg_valid; cfg_ready is always
//   high. Write only while no transaction is in flight.
// Pipeline: the depth from accept to result_valid is set by the fade path:
//   window tests, then a product and 16 restoring division steps for each
//   fade in series, then the output stage; the 32-step loop modulo runs
//   beside it.
// Throughput: one transaction per cycle while frame_stall is low.
// Reset: clears all valid bits and loads the register reset values.
// Stall: a stalled result freezes the whole pipeline; frame_stall follows
//   result_valid and result_stall, nothing is lost or repeated.
module clip_fade_gain_and_loop_address_top
  import cfgla_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     frame_valid,
  output logic                     frame_stall,
  input  logic [FRAME_BITS-1:0]    frame_offset,
  output logic                     result_valid,
  input  logic                     result_stall,
  output logic [FRAME_BITS:0]      source_frame,
  output logic                     in_range,
  output logic [GAIN_BITS-1:0]     gain,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data
);

  logic [GAIN_BITS-1:0]  linear_gain;
  logic [FRAME_BITS-1:0] fade_in_frames;
  logic [FRAME_BITS-1:0] fade_out_frames;
  logic [FRAME_BITS-1:0] start_frame;
  logic [FRAME_BITS-1:0] end_frame;
  logic                  muted;
  logic                  looped;
  logic [FRAME_BITS-1:0] clip_len;
  logic                  loop_en;

  cfgla_stage_t stg [0:LAST_STAGE];
  logic [LAST_STAGE:0] vld;
  logic adv;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      linear_gain     <= GAIN_RESET;
      fade_in_frames  <= '0;
      fade_out_frames <= '0;
      start_frame     <= '0;
      end_frame       <= '0;
      muted           <= 1'b0;
      looped          <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_LINEAR_GAIN: linear_gain     <= cfg_data[GAIN_BITS-1:0];
        REG_FADE_IN:     fade_in_frames  <= cfg_data[FRAME_BITS-1:0];
        REG_FADE_OUT:    fade_out_frames <= cfg_data[FRAME_BITS-1:0];
        REG_START:       start_frame     <= cfg_data[FRAME_BITS-1:0];
        REG_END:         end_frame       <= cfg_data[FRAME_BITS-1:0];
        REG_MUTED:       muted           <= cfg_data[0];
        REG_LOOPED:      looped          <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // clip length and loop enable, derived from stable config
  always_ff @(posedge clk) begin
    if (rst) begin
      clip_len <= '0;
      loop_en  <= 1'b0;
    end else begin
      clip_len <= end_frame - start_frame;
      loop_en  <= looped && (end_frame > start_frame);
    end
  end

  // global advance: only a held result blocks the pipeline
  assign adv         = !(vld[LAST_STAGE] && result_stall);
  assign frame_stall = !adv;

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[LAST_STAGE-1:0], frame_valid};
    end
  end

  // stage 0: window tests on the unwrapped offset
  cfgla_stage_t s0_next;
  always_comb begin
    logic signed [SGN_BITS-1:0] dur;
    logic signed [SGN_BITS-1:0] thr;
    logic signed [SGN_BITS-1:0] rem;
    logic signed [SGN_BITS-1:0] offs;
    offs = $signed({3'b000, frame_offset});
    dur  = $signed({3'b000, end_frame}) - $signed({3'b000, start_frame});
    thr  = dur - $signed({3'b000, fade_out_frames});
    rem  = dur - offs;
    s0_next          = '0;
    s0_next.off      = frame_offset;
    s0_next.g        = linear_gain;
    s0_next.fi_hit   = (fade_in_frames != '0) && (frame_offset < fade_in_frames);
    s0_next.fo_hit   = (fade_out_frames != '0) && (offs > thr);
    s0_next.fo_zero  = (rem <= 0);
    s0_next.rem      = rem[FRAME_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      stg[0] <= s0_next;
    end
  end

  // stages 1..LAST_STAGE: modulo steps, fade multiply and divide steps
  for (genvar s = 1; s <= LAST_STAGE; s++) begin : g_stage
    localparam int BIT = (s <= FRAME_BITS) ? FRAME_BITS - s : 0;
    cfgla_stage_t sn;

    always_comb begin
      logic [FRAME_BITS:0] ds;
      logic [GAIN_BITS+FRAME_BITS-1:0] prod;
      sn   = stg[s-1];
      ds   = '0;
      prod = '0;
      // loop modulo, one offset bit per stage
      if (s <= FRAME_BITS) begin
        ds     = div_step(sn.mr, sn.off[BIT], clip_len);
        sn.mr  = ds[FRAME_BITS:1];
      end
      // fade-in product, split into remainder and low dividend bits
      if (s == 1) begin
        prod  = (GAIN_BITS+FRAME_BITS)'(sn.g) * (GAIN_BITS+FRAME_BITS)'(sn.off);
        sn.rr = prod[GAIN_BITS+FRAME_BITS-1:GAIN_BITS];
        sn.lq = prod[GAIN_BITS-1:0];
      end
      // fade-in division steps
      if (s >= 2 && s <= GAIN_BITS + 1) begin
        ds    = div_step(sn.rr, sn.lq[GAIN_BITS-1], fade_in_frames);
        sn.rr = ds[FRAME_BITS:1];
        sn.lq = {sn.lq[GAIN_BITS-2:0], ds[0]};
        if (s == GAIN_BITS + 1 && sn.fi_hit) begin
          sn.g = sn.lq;
        end
      end
      // fade-out product
      if (s == GAIN_BITS + 2) begin
        prod  = (GAIN_BITS+FRAME_BITS)'(sn.g) * (GAIN_BITS+FRAME_BITS)'(sn.rem);
        sn.rr = prod[GAIN_BITS+FRAME_BITS-1:GAIN_BITS];
        sn.lq = prod[GAIN_BITS-1:0];
      end
      // fade-out division steps
      if (s >= GAIN_BITS + 3 && s <= FADE_END) begin
        ds    = div_step(sn.rr, sn.lq[GAIN_BITS-1], fade_out_frames);
        sn.rr = ds[FRAME_BITS:1];
        sn.lq = {sn.lq[GAIN_BITS-2:0], ds[0]};
        if (s == FADE_END && sn.fo_hit) begin
          sn.g = sn.fo_zero ? '0 : sn.lq;
        end
      end
      // source frame, range flag and mute
      if (s == LAST_STAGE) begin
        sn.src      = {1'b0, start_frame} + (loop_en ? {1'b0, sn.mr} : {1'b0, sn.off});
        sn.in_range = sn.src < {1'b0, end_frame};
        if (muted) begin
          sn.g = '0;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        stg[s] <= sn;
      end
    end
  end

  // result channel
  assign result_valid = vld[LAST_STAGE];
  assign source_frame = stg[LAST_STAGE].src;
  assign in_range     = stg[LAST_STAGE].in_range;
  assign gain         = stg[LAST_STAGE].g;

endmodule

[sv/cfgla_checker.sv]
// ----------------------------------------------------------------------------
// cfgla_port_assert
// port-level checks of the clip fade gain block, bound to the top level
// ----------------------------------------------------------------------------
`include "clip_fade_gain_and_loop_address_top_macros.svh"

module cfgla_port_assert
  import cfgla_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  frame_stall,
  input logic                  result_valid,
  input logic                  result_stall,
  input logic [FRAME_BITS:0]   source_frame,
  input logic                  in_range,
  input logic [GAIN_BITS-1:0]  gain
);

  // a held result stays valid
  `CFGLA_ASSERT_NEXT(a_hold_valid, result_valid && result_stall, result_valid)
  // a held result keeps its payload
  `CFGLA_ASSERT_NEXT(a_hold_data, result_valid && result_stall,
                     $stable(source_frame) && $stable(gain) && $stable(in_range))
  // the input side stalls only behind a held result
  `CFGLA_ASSERT_NOW(a_stall_cause, frame_stall, result_valid && result_stall)
  // reset empties the pipeline
  `CFGLA_ASSERT_NEXT_RST(a_reset_empty, rst, !result_valid && !frame_stall)

endmodule

bind clip_fade_gain_and_loop_address_top cfgla_port_assert u_cfgla_port_assert (
  .clk          (clk),
  .rst          (rst),
  .frame_stall  (frame_stall),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .source_frame (source_frame),
  .in_range     (in_range),
  .gain         (gain)
);
